### design/sdmn_pkg.sv
// Shared widths, constants, controller/datapath interface types and the small-divisor table.
package sdmn_pkg;

    localparam int WORD_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int CNT_W   = 5;

    localparam logic [WORD_W-1:0] HALF_RANGE = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAX_POS    = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SMALL_LO   = 32'd3;
    localparam logic [WORD_W-1:0] SMALL_HI   = 32'd12;
    localparam logic [CNT_W-1:0]  CNT_LAST   = {CNT_W{1'b1}};

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic take_a;
        logic take_b;
        logic iter;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic short_path;
        logic keep_going;
    } status_t;

    function automatic logic [WORD_W-1:0] small_magic(input logic [3:0] d);
        logic [WORD_W-1:0] m;
        case (d)
            4'd3:    m = 32'h5555_5556;
            4'd4:    m = 32'h0000_0000;
            4'd5:    m = 32'h6666_6667;
            4'd6:    m = 32'h2AAA_AAAB;
            4'd7:    m = 32'h9249_2493;
            4'd8:    m = 32'h0000_0000;
            4'd9:    m = 32'h38E3_8E39;
            4'd10:   m = 32'h6666_6667;
            4'd11:   m = 32'h2E8B_A2E9;
            4'd12:   m = 32'h2AAA_AAAB;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [SHIFT_W-1:0] small_shift(input logic [3:0] d);
        logic [SHIFT_W-1:0] s;
        case (d)
            4'd5:    s = 5'd1;
            4'd7:    s = 5'd2;
            4'd9:    s = 5'd1;
            4'd10:   s = 5'd2;
            4'd11:   s = 5'd1;
            4'd12:   s = 5'd1;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

### design/sdmn_datapath.sv
// Datapath: serial restoring divider, remainder doubling loop and result register.
module sdmn_datapath (
    input  logic                             aclk,
    input  logic signed [sdmn_pkg::WORD_W-1:0] s_divisor,
    input  sdmn_pkg::cmd_t                   cmd,
    output sdmn_pkg::status_t                status,
    output logic signed [sdmn_pkg::WORD_W-1:0] m_magic,
    output logic [sdmn_pkg::SHIFT_W-1:0]     m_extra_shift,
    output logic                             m_zero_divisor
);

    logic [sdmn_pkg::WORD_W-1:0]  ad_reg, ad_next;
    logic                         neg_reg;
    logic                         zero_reg;
    logic                         small_reg;
    logic [3:0]                   idx_reg;
    logic [sdmn_pkg::WORD_W-1:0]  rem_reg, rem_next;
    logic [sdmn_pkg::WORD_W-1:0]  quo_reg, quo_next;
    logic [sdmn_pkg::WORD_W-1:0]  anc_reg, anc_next;
    logic [sdmn_pkg::WORD_W-1:0]  q1_reg, q1_next;
    logic [sdmn_pkg::WORD_W-1:0]  r1_reg, r1_next;
    logic [sdmn_pkg::WORD_W-1:0]  q2_reg, q2_next;
    logic [sdmn_pkg::WORD_W-1:0]  r2_reg, r2_next;
    logic [sdmn_pkg::CNT_W-1:0]   count_reg;
    logic [sdmn_pkg::WORD_W-1:0]  magic_reg, magic_next;
    logic [sdmn_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                         zflag_reg;

    logic [sdmn_pkg::WORD_W-1:0]  div_u;
    logic                         in_zero;
    logic                         in_small;
    logic [sdmn_pkg::WORD_W-1:0]  div_d;
    logic [sdmn_pkg::WORD_W:0]    trial;
    logic [sdmn_pkg::WORD_W:0]    diff;
    logic                         ge;
    logic [sdmn_pkg::WORD_W-1:0]  r_inc;
    logic [sdmn_pkg::WORD_W-1:0]  t_rem;
    logic [sdmn_pkg::WORD_W-1:0]  anc_calc;
    logic [sdmn_pkg::WORD_W-1:0]  r1_dbl, r2_dbl;
    logic                         r1_ge, r2_ge;
    logic [sdmn_pkg::WORD_W-1:0]  delta;

    always_comb begin
        div_u    = $unsigned(s_divisor);
        in_zero  = (div_u == '0);
        in_small = !div_u[sdmn_pkg::WORD_W-1] && (div_u >= sdmn_pkg::SMALL_LO)
                   && (div_u <= sdmn_pkg::SMALL_HI);
        ad_next  = div_u[sdmn_pkg::WORD_W-1] ? (~div_u + 1'b1) : div_u;

        div_d = cmd.div_sel ? anc_reg : ad_reg;
        trial = {rem_reg, quo_reg[sdmn_pkg::WORD_W-1]};
        diff  = trial - {1'b0, div_d};
        ge    = (trial >= {1'b0, div_d});

        // The remainder of 2^31 + 1 follows from the remainder of 2^31.
        r_inc    = rem_reg + 1'b1;
        t_rem    = neg_reg ? ((r_inc == ad_reg) ? '0 : r_inc) : rem_reg;
        anc_calc = (neg_reg ? sdmn_pkg::HALF_RANGE : sdmn_pkg::MAX_POS) - t_rem;

        r1_dbl = {r1_reg[sdmn_pkg::WORD_W-2:0], 1'b0};
        r2_dbl = {r2_reg[sdmn_pkg::WORD_W-2:0], 1'b0};
        r1_ge  = (r1_dbl >= anc_reg);
        r2_ge  = (r2_dbl >= ad_reg);
        delta  = ad_reg - r2_reg;

        status.short_path = in_zero || in_small;
        status.keep_going = ((q1_reg < delta) || ((q1_reg == delta) && (r1_reg == '0)))
                            && (count_reg != sdmn_pkg::CNT_LAST);

        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = sdmn_pkg::HALF_RANGE;
        end else if (cmd.div_step) begin
            rem_next = ge ? diff[sdmn_pkg::WORD_W-1:0] : trial[sdmn_pkg::WORD_W-1:0];
            quo_next = {quo_reg[sdmn_pkg::WORD_W-2:0], ge};
        end

        anc_next = (anc_calc == '0) ? {{(sdmn_pkg::WORD_W-1){1'b0}}, 1'b1} : anc_calc;

        q1_next = q1_reg;
        r1_next = r1_reg;
        q2_next = q2_reg;
        r2_next = r2_reg;
        if (cmd.take_a) begin
            q2_next = quo_reg;
            r2_next = rem_reg;
        end else if (cmd.take_b) begin
            q1_next = quo_reg;
            r1_next = rem_reg;
        end else if (cmd.iter) begin
            q1_next = {q1_reg[sdmn_pkg::WORD_W-2:0], r1_ge};
            r1_next = r1_ge ? (r1_dbl - anc_reg) : r1_dbl;
            q2_next = {q2_reg[sdmn_pkg::WORD_W-2:0], r2_ge};
            r2_next = r2_ge ? (r2_dbl - ad_reg) : r2_dbl;
        end

        if (zero_reg) begin
            magic_next = '0;
            shift_next = '0;
        end else if (small_reg) begin
            magic_next = sdmn_pkg::small_magic(idx_reg);
            shift_next = sdmn_pkg::small_shift(idx_reg);
        end else begin
            magic_next = neg_reg ? ~q2_reg : (q2_reg + 1'b1);
            shift_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ad_reg    <= ad_next;
            neg_reg   <= div_u[sdmn_pkg::WORD_W-1];
            zero_reg  <= in_zero;
            small_reg <= in_small;
            idx_reg   <= div_u[3:0];
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.take_a) begin
            anc_reg <= anc_next;
        end
        q1_reg <= q1_next;
        r1_reg <= r1_next;
        q2_reg <= q2_next;
        r2_reg <= r2_next;
        if (cmd.take_b) begin
            count_reg <= sdmn_pkg::CNT_LAST;
        end else if (cmd.iter) begin
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load) begin
            magic_reg <= magic_next;
            shift_reg <= shift_next;
            zflag_reg <= zero_reg;
        end
    end

    assign m_magic        = $signed(magic_reg);
    assign m_extra_shift  = shift_reg;
    assign m_zero_divisor = zflag_reg;

endmodule

### design/sdmn_ctrl.sv
// Controller: sequences the two divisions and the doubling loop, and owns both handshakes.
module sdmn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  sdmn_pkg::status_t status,
    output sdmn_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_TAKE_A,
        ST_DIV_B,
        ST_TAKE_B,
        ST_ITER,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [sdmn_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = status.short_path ? ST_FINISH : ST_DIV_A;
                end
            end
            ST_DIV_A: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sdmn_pkg::CNT_LAST) begin
                    state_next = ST_TAKE_A;
                end
            end
            ST_TAKE_A: begin
                cmd.take_a   = 1'b1;
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_B;
            end
            ST_DIV_B: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sdmn_pkg::CNT_LAST) begin
                    state_next = ST_TAKE_B;
                end
            end
            ST_TAKE_B: begin
                cmd.take_b = 1'b1;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.iter   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.keep_going ? ST_ITER : ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### design/signed_division_magic_number_core.sv
// Top level of the signed-division magic number generator.
// Each input transfer carries a 32-bit signed divisor and yields one result transfer with
// the multiply-high magic number, the extra arithmetic right shift and a zero-divisor flag.
// A zero divisor and the divisors 3 to 12 skip both divisions and go straight to FINISH.
// Every other divisor runs two 32-step restoring divisions of 2^31 on one shared subtractor,
// followed by the doubling search, which passes through ITER and CHECK once per step.
// A finished result waits in an output register, so the next divisor is accepted while
// the previous result has not yet been taken.
module signed_division_magic_number_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sdmn_pkg::WORD_W-1:0] s_divisor,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [sdmn_pkg::WORD_W-1:0] m_magic,
    output logic [sdmn_pkg::SHIFT_W-1:0]       m_extra_shift,
    output logic                               m_zero_divisor
);

    sdmn_pkg::cmd_t    cmd;
    sdmn_pkg::status_t status;

    sdmn_datapath u_datapath (
        .aclk           (aclk),
        .s_divisor      (s_divisor),
        .cmd            (cmd),
        .status         (status),
        .m_magic        (m_magic),
        .m_extra_shift  (m_extra_shift),
        .m_zero_divisor (m_zero_divisor)
    );

    sdmn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

endmodule

### tb/signed_division_magic_number_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signed-division magic number core with its own predictor.
module signed_division_magic_number_core_test;

    typedef struct packed {
        logic signed [sdmn_pkg::WORD_W-1:0] magic;
        logic [sdmn_pkg::SHIFT_W-1:0]       extra_shift;
        logic                               zero_divisor;
    } magic_result_t;

    localparam logic [sdmn_pkg::WORD_W-1:0] TABLE_MAGIC [0:9] = '{
        32'h5555_5556, 32'h0000_0000, 32'h6666_6667, 32'h2AAA_AAAB, 32'h9249_2493,
        32'h0000_0000, 32'h38E3_8E39, 32'h6666_6667, 32'h2E8B_A2E9, 32'h2AAA_AAAB
    };
    localparam logic [sdmn_pkg::SHIFT_W-1:0] TABLE_SHIFT [0:9] = '{
        5'd0, 5'd0, 5'd1, 5'd0, 5'd2, 5'd0, 5'd1, 5'd2, 5'd1, 5'd1
    };
    localparam int SETTLE_CYCLES = 160;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [sdmn_pkg::WORD_W-1:0] s_divisor = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [sdmn_pkg::WORD_W-1:0] m_magic;
    logic [sdmn_pkg::SHIFT_W-1:0]       m_extra_shift;
    logic                               m_zero_divisor;

    magic_result_t expected_magic_q[$];
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            holdoff_len = 0;
    int            holdoff_seq = 0;

    signed_division_magic_number_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_divisor      (s_divisor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magic        (m_magic),
        .m_extra_shift  (m_extra_shift),
        .m_zero_divisor (m_zero_divisor)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic magic_result_t compute_magic(input logic [sdmn_pkg::WORD_W-1:0] d);
        magic_result_t res;
        logic          neg;
        logic [sdmn_pkg::WORD_W-1:0] ad, t, anc, q1, r1, q2, r2, delta, m;
        int            p, steps;
        int            shift_val;
        res = '0;
        neg = d[sdmn_pkg::WORD_W-1];
        if (d == '0) begin
            res.zero_divisor = 1'b1;
            return res;
        end
        if (!neg && d >= 32'd3 && d <= 32'd12) begin
            res.magic = TABLE_MAGIC[d - 32'd3];
            res.extra_shift = TABLE_SHIFT[d - 32'd3];
            return res;
        end
        ad = neg ? (32'd0 - d) : d;
        t = sdmn_pkg::HALF_RANGE + (neg ? 32'd1 : 32'd0);
        anc = t - 32'd1 - (t % ad);
        if (anc == '0) begin
            anc = 32'd1;
        end
        q1 = sdmn_pkg::HALF_RANGE / anc;
        r1 = sdmn_pkg::HALF_RANGE - q1 * anc;
        q2 = sdmn_pkg::HALF_RANGE / ad;
        r2 = sdmn_pkg::HALF_RANGE - q2 * ad;
        p = 31;
        steps = 0;
        do begin
            p++;
            steps++;
            q1 = q1 << 1;
            r1 = r1 << 1;
            if (r1 >= anc) begin
                q1 = q1 + 32'd1;
                r1 = r1 - anc;
            end
            q2 = q2 << 1;
            r2 = r2 << 1;
            if (r2 >= ad) begin
                q2 = q2 + 32'd1;
                r2 = r2 - ad;
            end
            delta = ad - r2;
        end while (steps < 32 && (q1 < delta || (q1 == delta && r1 == '0)));
        m = q2 + 32'd1;
        if (neg) begin
            m = 32'd0 - m;
        end
        res.magic = m;
        shift_val = p - 32;
        res.extra_shift = shift_val[sdmn_pkg::SHIFT_W-1:0];
        return res;
    endfunction

    function automatic logic [sdmn_pkg::WORD_W-1:0] pick_divisor();
        logic [sdmn_pkg::WORD_W-1:0] v;
        int                          k;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = 32'($urandom_range(0, 40)) - 32'd20;
            3: begin
                k = $urandom_range(0, 31);
                v = 32'd1 << k;
                if ($urandom_range(0, 1) == 1) begin
                    v = 32'd0 - v;
                end
                v = v + 32'($urandom_range(0, 2)) - 32'd1;
            end
            4: begin
                v = ($urandom_range(0, 1) == 1) ? sdmn_pkg::MAX_POS : sdmn_pkg::HALF_RANGE;
                v = v + 32'($urandom_range(0, 30)) - 32'd15;
            end
            default: v = 32'($urandom_range(0, 13));
        endcase
        return v;
    endfunction

    task automatic send_divisor(input logic [sdmn_pkg::WORD_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_divisor <= d;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_magic_q.push_back(compute_magic(d));
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (expected_magic_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Receiver: random stalls, plus long hold-offs requested by the tests.
    initial begin
        int seen_seq;
        int hold_left;
        seen_seq = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (holdoff_seq != seen_seq) begin
                seen_seq = holdoff_seq;
                hold_left = holdoff_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        magic_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_magic_q.size() == 0) begin
                $error("unexpected result transfer: magic %h, extra_shift %0d, zero_divisor %b",
                       m_magic, m_extra_shift, m_zero_divisor);
                mismatch_count++;
            end else begin
                want = expected_magic_q.pop_front();
                if (m_magic !== want.magic) begin
                    $error("magic: expected %h, actual %h", want.magic, m_magic);
                    mismatch_count++;
                end
                if (m_extra_shift !== want.extra_shift) begin
                    $error("extra_shift: expected %0d, actual %0d",
                           want.extra_shift, m_extra_shift);
                    mismatch_count++;
                end
                if (m_zero_divisor !== want.zero_divisor) begin
                    $error("zero_divisor: expected %b, actual %b",
                           want.zero_divisor, m_zero_divisor);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [sdmn_pkg::WORD_W-1:0] d;
        send_divisor(32'd0);
        send_divisor(32'd1);
        send_divisor(32'hFFFF_FFFF);
        send_divisor(32'd2);
        send_divisor(32'hFFFF_FFFE);
        for (d = 32'd3; d <= 32'd13; d++) begin
            send_divisor(d);
        end
        send_divisor(32'hFFFF_FFFD);
        send_divisor(32'hFFFF_FFF4);
        send_divisor(sdmn_pkg::MAX_POS);
        send_divisor(sdmn_pkg::HALF_RANGE);
        send_divisor(32'h8000_0001);
        send_divisor(32'h4000_0001);
        send_divisor(32'h5555_5555);
        send_divisor(32'hAAAA_AAAA);
        wait_results_done();
    endtask

    task automatic test_random(input int count);
        repeat (count) begin
            send_divisor(pick_divisor());
        end
        wait_results_done();
    endtask

    task automatic test_receiver_holdoff();
        holdoff_len = 1500;
        holdoff_seq++;
        repeat (16) begin
            send_divisor(pick_divisor());
        end
        wait_results_done();
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            repeat (8) begin
                send_divisor(pick_divisor());
            end
            wait_results_done();
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 27;
        recv_idle_pct = 75;
        test_directed();
        test_random(440);
        test_receiver_holdoff();

        send_idle_pct = 75;
        recv_idle_pct = 27;
        test_random(440);
        test_sender_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(440);
        test_receiver_holdoff();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS signed_division_magic_number_core");
        end else begin
            $display("FAIL signed_division_magic_number_core");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL signed_division_magic_number_core");
        $finish;
    end

endmodule

### filelist.f
design/sdmn_pkg.sv
design/sdmn_datapath.sv
design/sdmn_ctrl.sv
design/signed_division_magic_number_core.sv
tb/signed_division_magic_number_core_test.sv
